### design/sppd_pkg.sv
package sppd_pkg;

    // Delay store geometry (power of two)
    localparam int BUF_DEPTH = 65536;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);

    localparam int SAMPLE_W  = 24;
    localparam int GAIN_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int TDATA_W   = 2 * SAMPLE_W;

    localparam int TAP_MIN = 120;
    localparam int TAP_MAX = BUF_DEPTH - 8;

    // Compare width wide enough for the scaled right tap and for the depth bound
    localparam int QUOT_W = 17;
    localparam int CMP_W  = ((ADDR_W > QUOT_W) ? ADDR_W : QUOT_W) + 1;

    // Right tap = floor(dl * 112 / 100); /100 done as multiply by 2^30/100, rounded up.
    // Exact for every product below 2^23.
    localparam int XPROD_W     = 23;
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 30;
    localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;
    localparam logic [XPROD_W-1:0] TAP_RATIO = 23'd112;

    localparam logic [GAIN_W-1:0] FB_LIMIT    = 16'd60293;
    localparam logic [GAIN_W-1:0] CROSS_LIMIT = 16'd52429;

    localparam logic [GAIN_W-1:0] DELAY_RST    = 16'd18240;
    localparam logic [GAIN_W-1:0] FB_GAIN_RST  = 16'd22938;
    localparam logic [GAIN_W-1:0] CROSS_RST    = 16'd16384;
    localparam logic [GAIN_W-1:0] LP_COEFF_RST = 16'd16000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY_LEFT    = 2'd0,
        REG_FEEDBACK_GAIN = 2'd1,
        REG_CROSS_GAIN    = 2'd2,
        REG_LOWPASS_COEFF = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TAPL,
        ST_DIV,
        ST_TAPR,
        ST_MULG,
        ST_MULC,
        ST_SUM,
        ST_LPMUL,
        ST_LPUPD,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic tapl;
        logic div;
        logic tapr;
        logic mulg;
        logic mulc;
        logic sum;
        logic lpmul;
        logic lpupd;
        logic write;
    } dp_cmd_t;

    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [26:0] x);
        logic signed [SAMPLE_W-1:0] r;
        if (x > 27'sd8388607) begin
            r = 24'sh7FFFFF;
        end else if (x < -27'sd8388608) begin
            r = 24'sh800000;
        end else begin
            r = x[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] clamp_tap(input logic [CMP_W-1:0] d);
        logic [ADDR_W-1:0] r;
        if (d < CMP_W'(TAP_MIN)) begin
            r = ADDR_W'(TAP_MIN);
        end else if (d > CMP_W'(TAP_MAX)) begin
            r = ADDR_W'(TAP_MAX);
        end else begin
            r = d[ADDR_W-1:0];
        end
        return r;
    endfunction

endpackage

### design/sppd_ram.sv
module sppd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/sppd_ctrl.sv
module sppd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output sppd_pkg::dp_cmd_t cmd
);

    sppd_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sppd_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            sppd_pkg::ST_IDLE: begin
                // no word is taken while reset is held
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.load_in = 1'b1;
                    state_next  = sppd_pkg::ST_TAPL;
                end
            end
            sppd_pkg::ST_TAPL: begin
                cmd.tapl   = 1'b1;
                state_next = sppd_pkg::ST_DIV;
            end
            sppd_pkg::ST_DIV: begin
                cmd.div    = 1'b1;
                state_next = sppd_pkg::ST_TAPR;
            end
            sppd_pkg::ST_TAPR: begin
                cmd.tapr   = 1'b1;
                state_next = sppd_pkg::ST_MULG;
            end
            sppd_pkg::ST_MULG: begin
                cmd.mulg   = 1'b1;
                state_next = sppd_pkg::ST_MULC;
            end
            sppd_pkg::ST_MULC: begin
                cmd.mulc   = 1'b1;
                state_next = sppd_pkg::ST_SUM;
            end
            sppd_pkg::ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = sppd_pkg::ST_LPMUL;
            end
            sppd_pkg::ST_LPMUL: begin
                cmd.lpmul  = 1'b1;
                state_next = sppd_pkg::ST_LPUPD;
            end
            sppd_pkg::ST_LPUPD: begin
                cmd.lpupd  = 1'b1;
                state_next = sppd_pkg::ST_WRITE;
            end
            sppd_pkg::ST_WRITE: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_tready) begin
                    cmd.write  = 1'b1;
                    state_next = sppd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sppd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.write) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;

`ifndef ASSERT_OFF
    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(cmd))
        else $error("more than one datapath command active");

    a_write_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write |-> (!m_valid_reg || m_tready))
        else $error("result word overwritten before it was taken");

    a_write_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.write |=> (m_valid_reg && state_reg == sppd_pkg::ST_IDLE))
        else $error("result not presented after store write");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == sppd_pkg::ST_TAPL))
        else $error("accepted word did not start processing");
`endif

endmodule

### design/sppd_datapath.sv
module sppd_datapath (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  sppd_pkg::dp_cmd_t                     cmd,
    input  logic [sppd_pkg::TDATA_W-1:0]          in_data,
    output logic [sppd_pkg::TDATA_W-1:0]          out_data,
    input  logic                                  cfg_wr_en,
    input  logic [sppd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [sppd_pkg::GAIN_W-1:0]           cfg_wdata
);

    localparam int SW = sppd_pkg::SAMPLE_W;
    localparam int AW = sppd_pkg::ADDR_W;
    localparam int GW = sppd_pkg::GAIN_W;
    localparam int MW = SW + GW + 1;     // tap * gain product
    localparam int DW = MW + 1;          // sum of two products, also lowpass product

    // configuration
    logic [GW-1:0] delay_reg, fb_gain_reg, cross_reg, lp_coeff_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg    <= sppd_pkg::DELAY_RST;
            fb_gain_reg  <= sppd_pkg::FB_GAIN_RST;
            cross_reg    <= sppd_pkg::CROSS_RST;
            lp_coeff_reg <= sppd_pkg::LP_COEFF_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                sppd_pkg::REG_DELAY_LEFT:    delay_reg    <= cfg_wdata;
                sppd_pkg::REG_FEEDBACK_GAIN: fb_gain_reg  <= cfg_wdata;
                sppd_pkg::REG_CROSS_GAIN:    cross_reg    <= cfg_wdata;
                sppd_pkg::REG_LOWPASS_COEFF: lp_coeff_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // control state: store write pointer, wrap flag and lowpass states
    logic [AW-1:0] wp_reg;
    logic          wrapped_reg;
    logic signed [SW-1:0] lp_l_reg, lp_r_reg;

    // payload registers
    logic signed [SW-1:0] in_l_reg, in_r_reg;
    logic [sppd_pkg::XPROD_W-1:0] xprod_reg;
    logic [sppd_pkg::QUOT_W-1:0]  quot_reg;
    logic [AW-1:0]        raddr_l, raddr_r;
    logic                 valid_l_reg, valid_r_reg;
    logic signed [MW-1:0] pg_l_reg, pg_r_reg, pc_l_reg, pc_r_reg;
    logic signed [SW-1:0] sum_l_reg, sum_r_reg;
    logic signed [DW-1:0] lpm_l_reg, lpm_r_reg;
    logic signed [SW-1:0] out_l_reg, out_r_reg;

    logic [AW-1:0]        dl, dr;
    logic [sppd_pkg::XPROD_W+sppd_pkg::RECIP_W-1:0] qprod;
    logic [SW-1:0]        rd_l, rd_r;
    logic signed [SW-1:0] tap_l, tap_r;
    logic [GW-1:0]        g_lim, c_lim;
    logic signed [GW:0]   g_s, c_s, a_s;
    logic signed [DW-1:0] acc_l, acc_r;
    logic signed [SW:0]   diff_l, diff_r;
    logic signed [SW-1:0] st_l, st_r;

    assign dl      = sppd_pkg::clamp_tap(sppd_pkg::CMP_W'(delay_reg));
    assign raddr_l = wp_reg - dl;
    assign qprod   = (sppd_pkg::XPROD_W+sppd_pkg::RECIP_W)'(xprod_reg)
                   * (sppd_pkg::XPROD_W+sppd_pkg::RECIP_W)'(sppd_pkg::RECIP_100);
    assign dr      = sppd_pkg::clamp_tap(sppd_pkg::CMP_W'(quot_reg));
    assign raddr_r = wp_reg - dr;

    // entries not yet written since reset read as zero
    assign tap_l = valid_l_reg ? $signed(rd_l) : '0;
    assign tap_r = valid_r_reg ? $signed(rd_r) : '0;

    assign g_lim = (fb_gain_reg > sppd_pkg::FB_LIMIT) ? sppd_pkg::FB_LIMIT : fb_gain_reg;
    assign c_lim = (cross_reg > sppd_pkg::CROSS_LIMIT) ? sppd_pkg::CROSS_LIMIT : cross_reg;
    assign g_s   = $signed({1'b0, g_lim});
    assign c_s   = $signed({1'b0, c_lim});
    assign a_s   = $signed({1'b0, lp_coeff_reg});

    assign acc_l  = {pg_l_reg[MW-1], pg_l_reg} + {pc_l_reg[MW-1], pc_l_reg};
    assign acc_r  = {pg_r_reg[MW-1], pg_r_reg} + {pc_r_reg[MW-1], pc_r_reg};
    assign diff_l = {sum_l_reg[SW-1], sum_l_reg} - {lp_l_reg[SW-1], lp_l_reg};
    assign diff_r = {sum_r_reg[SW-1], sum_r_reg} - {lp_r_reg[SW-1], lp_r_reg};

    assign st_l = sppd_pkg::sat24({{3{in_l_reg[SW-1]}}, in_l_reg}
                                + {{3{lp_l_reg[SW-1]}}, lp_l_reg});
    assign st_r = sppd_pkg::sat24({{3{in_r_reg[SW-1]}}, in_r_reg}
                                + {{3{lp_r_reg[SW-1]}}, lp_r_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            wrapped_reg <= 1'b0;
            lp_l_reg    <= '0;
            lp_r_reg    <= '0;
        end else begin
            if (cmd.lpupd) begin
                // state += (alpha * (x - state)) >>> 16
                lp_l_reg <= sppd_pkg::sat24({{3{lp_l_reg[SW-1]}}, lp_l_reg}
                                          + {lpm_l_reg[DW-1], lpm_l_reg[DW-1:GW]});
                lp_r_reg <= sppd_pkg::sat24({{3{lp_r_reg[SW-1]}}, lp_r_reg}
                                          + {lpm_r_reg[DW-1], lpm_r_reg[DW-1:GW]});
            end
            if (cmd.write) begin
                wp_reg <= wp_reg + AW'(1);
                if (&wp_reg) begin
                    wrapped_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_l_reg <= $signed(in_data[SW-1:0]);
            in_r_reg <= $signed(in_data[2*SW-1:SW]);
        end
        if (cmd.tapl) begin
            xprod_reg   <= sppd_pkg::XPROD_W'(dl) * sppd_pkg::TAP_RATIO;
            valid_l_reg <= wrapped_reg || (raddr_l < wp_reg);
        end
        if (cmd.div) begin
            quot_reg <= qprod[sppd_pkg::RECIP_SHIFT +: sppd_pkg::QUOT_W];
        end
        if (cmd.tapr) begin
            valid_r_reg <= wrapped_reg || (raddr_r < wp_reg);
        end
        if (cmd.mulg) begin
            pg_l_reg <= tap_l * g_s;
            pg_r_reg <= tap_r * g_s;
        end
        if (cmd.mulc) begin
            pc_l_reg <= tap_r * c_s;
            pc_r_reg <= tap_l * c_s;
        end
        if (cmd.sum) begin
            sum_l_reg <= sppd_pkg::sat24({acc_l[DW-1], acc_l[DW-1:GW]});
            sum_r_reg <= sppd_pkg::sat24({acc_r[DW-1], acc_r[DW-1:GW]});
        end
        if (cmd.lpmul) begin
            lpm_l_reg <= diff_l * a_s;
            lpm_r_reg <= diff_r * a_s;
        end
        if (cmd.write) begin
            out_l_reg <= tap_l;
            out_r_reg <= tap_r;
        end
    end

    sppd_ram #(.WIDTH(SW), .DEPTH(sppd_pkg::BUF_DEPTH)) u_left_store (
        .aclk  (aclk),
        .we    (cmd.write),
        .waddr (wp_reg),
        .wdata (st_l),
        .re    (cmd.tapl),
        .raddr (raddr_l),
        .rdata (rd_l)
    );

    sppd_ram #(.WIDTH(SW), .DEPTH(sppd_pkg::BUF_DEPTH)) u_right_store (
        .aclk  (aclk),
        .we    (cmd.write),
        .waddr (wp_reg),
        .wdata (st_r),
        .re    (cmd.tapr),
        .raddr (raddr_r),
        .rdata (rd_r)
    );

    assign out_data = {out_r_reg, out_l_reg};

endmodule

### design/stereo_ping_pong_delay_top.sv
// Stereo ping-pong delay with damped cross feedback.
// s_ channel: one stereo input word per transfer (tvalid/tready).
// m_ channel: one wet stereo word per accepted input word, in order.
// Config port: cfg_wr_en writes cfg_wdata into register cfg_index
// (0 left delay, 1 feedback gain, 2 cross gain, 3 lowpass coefficient)
// on the clock edge; write only while no word is in flight.
// Each accepted word runs through a fixed step sequence: left store read,
// reciprocal multiply for the right tap, right store read, two gain multiply
// steps, saturate, lowpass multiply, lowpass update and store write; the result
// then shows on m_tvalid, and a new word is taken only after the sequence ends.
// The output register frees s_tready as soon as the store write is done, so a
// new word is accepted while the last result still waits; if the receiver
// stalls, processing halts in the store-write step until the result is taken.
// Reset (aresetn low, synchronous) restores the register defaults, clears the
// lowpass state and write pointer; unwritten store entries read as zero via
// a wrap flag, so there is no clearing pass and the block is ready at once.
module stereo_ping_pong_delay_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sppd_pkg::TDATA_W-1:0]      s_tdata,   // left_sample, right_sample
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sppd_pkg::TDATA_W-1:0]      m_tdata,   // wet_left, wet_right
    input  logic                              cfg_wr_en,
    input  logic [sppd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sppd_pkg::GAIN_W-1:0]       cfg_wdata
);

    sppd_pkg::dp_cmd_t cmd;

    sppd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    sppd_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .in_data   (s_tdata),
        .out_data  (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

endmodule

### verif/tb_stereo_ping_pong_delay_top.sv
module tb_stereo_ping_pong_delay_top;
    import sppd_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SHOWN_MISMATCHES = 25;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_e;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] wet_r;
        logic signed [SAMPLE_W-1:0] wet_l;
    } wet_pair_t;

    // Mirrors both delay lines, the lowpass states and the register file;
    // each accepted dry word queues the wet word the block must return.
    class echo_tracker;
        logic signed [SAMPLE_W-1:0] left_mem [BUF_DEPTH];
        logic signed [SAMPLE_W-1:0] right_mem [BUF_DEPTH];
        logic [ADDR_W-1:0] wr_ptr;
        logic signed [SAMPLE_W-1:0] lp_l;
        logic signed [SAMPLE_W-1:0] lp_r;
        logic [GAIN_W-1:0] delay_reg;
        logic [GAIN_W-1:0] feedback_reg;
        logic [GAIN_W-1:0] cross_reg;
        logic [GAIN_W-1:0] lp_reg;
        wet_pair_t wet_due[$];
        int errors;
        int words_seen;
        int words_checked;
        int fb_clips;
        int store_clips;

        function new();
            foreach (left_mem[i]) begin
                left_mem[i] = '0;
                right_mem[i] = '0;
            end
            wr_ptr = '0;
            lp_l = '0;
            lp_r = '0;
            delay_reg = DELAY_RST;
            feedback_reg = FB_GAIN_RST;
            cross_reg = CROSS_RST;
            lp_reg = LP_COEFF_RST;
            errors = 0;
            words_seen = 0;
            words_checked = 0;
            fb_clips = 0;
            store_clips = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [GAIN_W-1:0] val);
            case (idx)
                REG_DELAY_LEFT:    delay_reg = val;
                REG_FEEDBACK_GAIN: feedback_reg = val;
                REG_CROSS_GAIN:    cross_reg = val;
                REG_LOWPASS_COEFF: lp_reg = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return wet_due.size();
        endfunction

        function logic signed [SAMPLE_W-1:0] clip24(longint v);
            if (v > 64'sd8388607) begin
                return 24'sh7FFFFF;
            end else if (v < -64'sd8388608) begin
                return 24'sh800000;
            end
            return v[SAMPLE_W-1:0];
        endfunction

        function int unsigned clamp_dist(int unsigned d);
            if (d < TAP_MIN) begin
                return TAP_MIN;
            end else if (d > TAP_MAX) begin
                return TAP_MAX;
            end
            return d;
        endfunction

        // one-pole step: prev + alpha*(x - prev) >>> 16, clipped
        function logic signed [SAMPLE_W-1:0] smooth(logic signed [SAMPLE_W-1:0] prev,
                                                    logic signed [SAMPLE_W-1:0] x);
            longint step;
            step = (longint'(lp_reg) * (longint'(x) - longint'(prev))) >>> 16;
            return clip24(longint'(prev) + step);
        endfunction

        function void take_dry_pair(logic signed [SAMPLE_W-1:0] dry_l,
                                    logic signed [SAMPLE_W-1:0] dry_r);
            int unsigned dist_l;
            int unsigned dist_r;
            logic [ADDR_W-1:0] rd_l;
            logic [ADDR_W-1:0] rd_r;
            logic signed [SAMPLE_W-1:0] tap_l;
            logic signed [SAMPLE_W-1:0] tap_r;
            longint fb_g;
            longint cross_c;
            longint raw_l;
            longint raw_r;
            longint mix_l;
            longint mix_r;
            wet_pair_t due;
            dist_l = clamp_dist(int'(delay_reg));
            dist_r = clamp_dist(dist_l * 112 / 100);
            rd_l = wr_ptr - ADDR_W'(dist_l);
            rd_r = wr_ptr - ADDR_W'(dist_r);
            tap_l = left_mem[rd_l];
            tap_r = right_mem[rd_r];
            fb_g = (feedback_reg > FB_LIMIT) ? longint'(FB_LIMIT) : longint'(feedback_reg);
            cross_c = (cross_reg > CROSS_LIMIT) ? longint'(CROSS_LIMIT) : longint'(cross_reg);
            raw_l = (longint'(tap_l) * fb_g + longint'(tap_r) * cross_c) >>> 16;
            raw_r = (longint'(tap_r) * fb_g + longint'(tap_l) * cross_c) >>> 16;
            if (raw_l != longint'(clip24(raw_l)) || raw_r != longint'(clip24(raw_r))) begin
                fb_clips++;
            end
            lp_l = smooth(lp_l, clip24(raw_l));
            lp_r = smooth(lp_r, clip24(raw_r));
            mix_l = longint'(dry_l) + longint'(lp_l);
            mix_r = longint'(dry_r) + longint'(lp_r);
            if (mix_l != longint'(clip24(mix_l)) || mix_r != longint'(clip24(mix_r))) begin
                store_clips++;
            end
            left_mem[wr_ptr] = clip24(mix_l);
            right_mem[wr_ptr] = clip24(mix_r);
            wr_ptr++;
            due.wet_l = tap_l;
            due.wet_r = tap_r;
            wet_due.push_back(due);
            words_seen++;
        endfunction

        task report_mismatch(string what);
            if (errors < SHOWN_MISMATCHES) begin
                $display("MISMATCH word %0d: %s", words_checked, what);
            end
            errors++;
        endtask

        task match_wet_pair(logic [TDATA_W-1:0] word);
            wet_pair_t due;
            wet_pair_t got;
            got = word;
            if (wet_due.size() == 0) begin
                report_mismatch($sformatf("unexpected wet word %h", word));
            end else begin
                due = wet_due.pop_front();
                if (got.wet_l !== due.wet_l) begin
                    report_mismatch($sformatf("wet_left %h, want %h", got.wet_l, due.wet_l));
                end
                if (got.wet_r !== due.wet_r) begin
                    report_mismatch($sformatf("wet_right %h, want %h", got.wet_r, due.wet_r));
                end
            end
            words_checked++;
        endtask
    endclass

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [TDATA_W-1:0] s_tdata;   // left_sample, right_sample
    logic m_tvalid;
    logic m_tready;
    logic [TDATA_W-1:0] m_tdata;   // wet_left, wet_right
    logic cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [GAIN_W-1:0] cfg_wdata;

    echo_tracker board;
    idle_mode_e idle_mode;
    int quiet_cycles;
    int rx_hold;
    int phase_count;

    stereo_ping_pong_delay_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    function automatic bit roll_idle(bit sender_side);
        int pct;
        pct = 0;
        case (idle_mode)
            IDLE_SENDER:   pct = sender_side ? 55 : 0;
            IDLE_RECEIVER: pct = sender_side ? 0 : 55;
            IDLE_BOTH:     pct = 35;
            default:       pct = 0;
        endcase
        return $urandom_range(99) < pct;
    endfunction

    // full-range values half the time, with rails, near-rail and near-silence values mixed in
    function automatic logic [SAMPLE_W-1:0] random_sample();
        logic [SAMPLE_W-1:0] v;
        case ($urandom_range(7))
            0: v = 24'h7FFFFF;
            1: v = 24'h800000;
            2: v = SAMPLE_W'($urandom_range(511)) - 24'd256;
            3: v = 24'h7FFFFF - SAMPLE_W'($urandom_range(65535));
            default: v = SAMPLE_W'($urandom);
        endcase
        return v;
    endfunction

    // receiver: random stalls of random length at the falling edge
    always @(negedge aclk) begin
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else if (roll_idle(1'b0)) begin
            m_tready <= 1'b0;
            rx_hold <= $urandom_range(12);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // both channels are observed at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                board.take_dry_pair(s_tdata[SAMPLE_W-1:0], s_tdata[TDATA_W-1:SAMPLE_W]);
            end
            if (m_tvalid && m_tready) begin
                board.match_wet_pair(m_tdata);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", quiet_cycles);
                $display("tb_stereo_ping_pong_delay_top: errors");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // entered and left at a falling edge; s_tvalid stays high between words but for rolled idle gaps
    task automatic send_pair(logic [SAMPLE_W-1:0] dry_l, logic [SAMPLE_W-1:0] dry_r);
        if (roll_idle(1'b1)) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_tdata = {dry_r, dry_l};
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain_block();
        s_tvalid = 1'b0;
        while (board.pending() != 0) @(negedge aclk);
        repeat (12) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [GAIN_W-1:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        board.set_reg(idx, val);
        @(negedge aclk);
    endtask

    task automatic run_phase(int delay_val, int fb_val, int cross_val, int lp_val,
                             idle_mode_e mode, int words);
        drain_block();
        write_reg(REG_DELAY_LEFT, GAIN_W'(delay_val));
        write_reg(REG_FEEDBACK_GAIN, GAIN_W'(fb_val));
        write_reg(REG_CROSS_GAIN, GAIN_W'(cross_val));
        write_reg(REG_LOWPASS_COEFF, GAIN_W'(lp_val));
        cfg_wr_en = 1'b0;
        idle_mode = mode;
        repeat (words) send_pair(random_sample(), random_sample());
        s_tvalid = 1'b0;
        phase_count++;
    endtask

    initial begin
        logic [SAMPLE_W-1:0] corner [9];
        corner = '{24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF, 24'h000001,
                   24'h555555, 24'hAAAAAA, 24'h400000, 24'hC00000};
        board = new();
        aclk = 1'b0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_DELAY_LEFT;
        cfg_wdata = '0;
        idle_mode = IDLE_NONE;
        quiet_cycles = 0;
        rx_hold = 0;
        phase_count = 0;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        // rails and bit patterns on both channels, reset register values
        for (int i = 0; i < 9; i++) begin
            send_pair(corner[i], corner[8 - i]);
            send_pair(corner[i], corner[i]);
        end
        s_tvalid = 1'b0;
        phase_count++;

        // short taps with gains above their limits: feedback and store clip
        run_phase(0, 65535, 65535, 65535, IDLE_NONE, 280);
        run_phase(130, FB_LIMIT, CROSS_LIMIT, 16000, IDLE_SENDER, 280);
        run_phase(200, 0, 0, 0, IDLE_RECEIVER, 240);
        run_phase(150, $urandom_range(65535), $urandom_range(65535),
                  $urandom_range(65535), IDLE_BOTH, 280);
        // longest tap, clamped below the depth
        run_phase(65535, 22938, 16384, 16000, IDLE_BOTH, 140);
        run_phase(1000, $urandom_range(FB_LIMIT), $urandom_range(CROSS_LIMIT),
                  $urandom_range(65535), IDLE_NONE, 280);

        drain_block();
        $display("%0d stereo words checked over %0d register settings, taps 120 to %0d",
                 board.words_checked, phase_count, TAP_MAX);
        $display("feedback sums clipped on %0d words, store writes clipped on %0d",
                 board.fb_clips, board.store_clips);
        if (board.errors == 0) begin
            $display("tb_stereo_ping_pong_delay_top: clean");
        end else begin
            $display("tb_stereo_ping_pong_delay_top: errors");
        end
        $finish;
    end

endmodule
